FILE: hw/rtl/drm_pkg.sv
// Shared constants, register indexes and widths for the drift retime multiplier.
package drm_pkg;

    // Fixed field widths
    localparam int DRIFT_W    = 32;
    localparam int MULT_W     = 18;
    localparam int CORR_W     = 17;
    localparam int SMOOTH_W   = 17;
    localparam int DB_W       = 24;
    localparam int FULL_W     = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // Default number of fraction bits (Q16)
    localparam int DEF_FRAC_BITS = 16;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_ON   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_DIST = 3'd4;

    // Register reset values
    localparam logic                RST_CORR_ON   = 1'b1;
    localparam logic [CORR_W-1:0]   RST_MAX_CORR  = 17'd3277;
    localparam logic [SMOOTH_W-1:0] RST_SMOOTHING = 17'd6554;
    localparam logic [DB_W-1:0]     RST_DEADBAND  = 24'd480;
    localparam logic [FULL_W-1:0]   RST_FULL_DIST = 25'd4800;

endpackage

FILE: hw/rtl/drm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module drm_div_pipe
    import drm_pkg::*;
#(
    parameter int NW = 43,  // numerator width
    parameter int DW = 25,  // divisor width
    parameter int QW = 17,  // quotient width (quotient known to fit)
    parameter int SW = 1    // sideband width
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [QW];
    logic [NW-1:0] r_rem  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;

        logic          vld_in;
        logic [NW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_in;
        logic [NW-1:0] shd;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = i_num;
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign quo_in  = r_quo[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        // divisor aligned to this stage's quotient bit
        assign shd = NW'(den_in) << B;

        // trial subtract
        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            if (rem_in >= shd) begin
                n_rem    = rem_in - shd;
                n_quo[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_quo[k]  <= n_quo;
            r_den[k]  <= den_in;
            r_side[k] <= side_in;
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule

FILE: hw/rtl/drift_retime_multiplier_top.sv
// Drift retime multiplier: pipelined playback-rate correction.
// A beat taken passes stages 1 to 3, the quotient pipeline, the product stage and the
//   output stage before it shows o_valid.
// Throughput: one beat per cycle; busy is low except during reset and in the cycle after it.
// The quotient pipeline (one bit per stage, FRAC_BITS + 1 stages) sets the depth.
// Reset is synchronous and clears valid bits and config to defaults.
module drift_retime_multiplier_top
    import drm_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DRIFT_W-1:0]    i_drift,
    input  logic        [MULT_W-1:0]     i_prev_multiplier,
    output logic                         o_valid,
    output logic        [MULT_W-1:0]     o_multiplier,
    input  logic                         i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data
);

    // Derived widths
    localparam int ONE_W = FRAC_BITS + 1;                       // holds 1.0
    localparam int VW    = (FRAC_BITS + 2 > MULT_W) ? FRAC_BITS + 2 : MULT_W;
    localparam int MAG_W = DRIFT_W - 1;
    localparam int NW    = ONE_W + FULL_W + 1;                  // corr*over + span/2
    localparam int QW    = ONE_W;
    localparam int PW    = VW + ONE_W + 2;                      // smoothing product

    localparam logic [VW-1:0] ONE_V  = VW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] HALF_N = HALF_P - PW'(1);

    typedef struct packed {
        logic          neg;
        logic          active;
        logic [VW-1:0] prev;
    } t_side;

    localparam int SW = $bits(t_side);

    // ---------------- config registers
    logic                r_corr_on;
    logic [CORR_W-1:0]   r_max_corr;
    logic [SMOOTH_W-1:0] r_smoothing;
    logic [DB_W-1:0]     r_deadband;
    logic [FULL_W-1:0]   r_full_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corr_on   <= RST_CORR_ON;
            r_max_corr  <= RST_MAX_CORR;
            r_smoothing <= RST_SMOOTHING;
            r_deadband  <= RST_DEADBAND;
            r_full_dist <= RST_FULL_DIST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CORR_ON:   r_corr_on   <= i_cfg_data[0];
                CFG_MAX_CORR:  r_max_corr  <= i_cfg_data[CORR_W-1:0];
                CFG_SMOOTHING: r_smoothing <= i_cfg_data[SMOOTH_W-1:0];
                CFG_DEADBAND:  r_deadband  <= i_cfg_data[DB_W-1:0];
                CFG_FULL_DIST: r_full_dist <= i_cfg_data[FULL_W-1:0];
                default: ;
            endcase
        end
    end

    // Busy during reset and in the cycle that follows reset
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    // ---------------- values derived from config (the user keeps them static while items fly; not enforced)
    logic [VW-1:0]     corr_v;
    logic [VW-1:0]     s_v;
    logic [VW-1:0]     lo_v;
    logic [VW-1:0]     hi_v;
    logic [FULL_W-1:0] db_p1;
    logic [FULL_W-1:0] full_c;
    logic [FULL_W-1:0] span;

    always_comb begin
        corr_v = (VW'(r_max_corr) > ONE_V) ? ONE_V : VW'(r_max_corr);
        s_v    = (VW'(r_smoothing) > ONE_V) ? ONE_V : VW'(r_smoothing);
        lo_v   = ONE_V - corr_v;
        hi_v   = ONE_V + corr_v;
        db_p1  = FULL_W'(r_deadband) + FULL_W'(1);
        full_c = (r_full_dist < db_p1) ? db_p1 : r_full_dist;
        span   = full_c - FULL_W'(r_deadband);
    end

    // ---------------- stage 1: drift magnitude, clamp of previous value
    logic               accept;
    logic [DRIFT_W-1:0] drift_neg;
    logic [MAG_W-1:0]   n1_mag;
    logic [VW-1:0]      prev_in;
    logic [VW-1:0]      n1_prev;

    logic               r1_vld;
    logic               r1_neg;
    logic [MAG_W-1:0]   r1_mag;
    logic [VW-1:0]      r1_prev;

    assign accept = start && !r_busy;

    always_comb begin
        drift_neg = ~i_drift + DRIFT_W'(1);
        if (i_drift[DRIFT_W-1]) begin
            // the most negative drift saturates
            n1_mag = drift_neg[DRIFT_W-1] ? {MAG_W{1'b1}} : drift_neg[MAG_W-1:0];
        end else begin
            n1_mag = i_drift[MAG_W-1:0];
        end
        prev_in = VW'(i_prev_multiplier);
        if (prev_in < lo_v) begin
            n1_prev = lo_v;
        end else if (prev_in > hi_v) begin
            n1_prev = hi_v;
        end else begin
            n1_prev = prev_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_neg  <= i_drift[DRIFT_W-1];
        r1_mag  <= n1_mag;
        r1_prev <= n1_prev;
    end

    // ---------------- stage 2: distance past the deadband
    logic [MAG_W-1:0]  over_raw;
    logic              n2_active;
    logic [FULL_W-1:0] n2_over;

    logic              r2_vld;
    logic              r2_neg;
    logic              r2_active;
    logic [FULL_W-1:0] r2_over;
    logic [VW-1:0]     r2_prev;

    always_comb begin
        over_raw  = r1_mag - MAG_W'(r_deadband);
        n2_active = r_corr_on && (r1_mag > MAG_W'(r_deadband));
        if (!n2_active) begin
            n2_over = '0;
        end else if (over_raw > MAG_W'(span)) begin
            n2_over = span;
        end else begin
            n2_over = over_raw[FULL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_neg    <= r1_neg;
        r2_active <= n2_active;
        r2_over   <= n2_over;
        r2_prev   <= r1_prev;
    end

    // ---------------- stage 3: rounded numerator corr*over + span/2
    logic [NW-1:0] n3_num;
    logic          r3_vld;
    logic [NW-1:0] r3_num;
    t_side         r3_side;

    assign n3_num = NW'(corr_v[ONE_W-1:0]) * NW'(r2_over) + NW'(span >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_num         <= n3_num;
        r3_side.neg    <= r2_neg;
        r3_side.active <= r2_active;
        r3_side.prev   <= r2_prev;
    end

    // ---------------- delta = round(corr*over / span)
    logic          dv_vld;
    logic [QW-1:0] dv_quo;
    t_side         dv_side;

    drm_div_pipe #(
        .NW (NW),
        .DW (FULL_W),
        .QW (QW),
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_num   (r3_num),
        .i_den   (span),
        .i_side  (r3_side),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // ---------------- product stage: (target - prev) * s
    logic [VW-1:0]        target;
    logic signed [VW:0]   diff;
    logic signed [ONE_W:0] s_sg;
    logic signed [PW-1:0] n_prod;

    logic                 r_p_vld;
    logic signed [PW-1:0] r_prod;
    logic [VW-1:0]        r_p_prev;

    always_comb begin
        if (!dv_side.active) begin
            target = ONE_V;
        end else if (dv_side.neg) begin
            target = ONE_V - VW'(dv_quo);
        end else begin
            target = ONE_V + VW'(dv_quo);
        end
        diff   = signed'({1'b0, target}) - signed'({1'b0, dv_side.prev});
        s_sg   = signed'({1'b0, s_v[ONE_W-1:0]});
        n_prod = PW'(diff) * PW'(s_sg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_p_prev <= dv_side.prev;
    end

    // ---------------- output stage: round, add, clamp
    logic signed [PW-1:0] bias;
    logic signed [PW-1:0] step;
    logic signed [PW-1:0] res;
    logic signed [PW-1:0] lo_p;
    logic signed [PW-1:0] hi_p;
    logic [VW-1:0]        n_out;

    logic                 r_o_vld;
    logic [MULT_W-1:0]    r_o_mult;

    always_comb begin
        // round half away from zero: negative products take half minus one
        bias = r_prod[PW-1] ? signed'(HALF_N) : signed'(HALF_P);
        step = (r_prod + bias) >>> FRAC_BITS;
        res  = signed'(PW'(r_p_prev)) + step;
        lo_p = signed'(PW'(lo_v));
        hi_p = signed'(PW'(hi_v));
        // with correction off the sum lies between prev and 1.0: clamp is a no-op
        if (res < lo_p) begin
            n_out = lo_v;
        end else if (res > hi_p) begin
            n_out = hi_v;
        end else begin
            n_out = res[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_mult <= n_out[MULT_W-1:0];
    end

    assign o_valid      = r_o_vld;
    assign o_multiplier = r_o_mult;

endmodule

FILE: hw/rtl/drm_checker.sv
// Port-level checker for the drift retime multiplier, bound to the top level.
module drm_checker
    import drm_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [MULT_W-1:0]     o_multiplier
);

    localparam int LAT = FRAC_BITS + 6;

    // Every accepted beat comes out as a matching result strobe
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted beat produced no result on time");

    // No result without a beat accepted at the matching edge
    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without matching accepted beat");

    // Reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // At Q16 or coarser ports the result stays within [0, 2.0]
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (FRAC_BITS <= 16)) |-> (o_multiplier <= (MULT_W'(1) << (FRAC_BITS + 1))))
        else $error("multiplier beyond twice unity");

endmodule

bind drift_retime_multiplier_top drm_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_drm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_multiplier (o_multiplier)
);
